### hw/rtl/polyline_extrude_to_polygon_assert.svh
// assertion macros for the polyline extruder checks
// needs a clock and an active-low synchronous reset at the place of use
`ifndef POLYLINE_EXTRUDE_TO_POLYGON_ASSERT_SVH
`define POLYLINE_EXTRUDE_TO_POLYGON_ASSERT_SVH

// same-cycle implication
`define PLE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ple check failed");

// next-cycle implication
`define PLE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ple check failed");

`endif

### hw/rtl/ple_pkg.sv
// shared types and constants of the polyline extruder
// used by the interfaces, the top level and the checker
package ple_pkg;

    localparam int MAX_POINTS_DEF = 32;
    localparam int COORD_W        = 15;
    localparam int VTX_W          = 16;
    localparam int TW_W           = 10;
    localparam logic [TW_W-1:0] TW_RESET = 10'd40;

    // magnitude and arithmetic widths
    localparam int DIFF_W  = 16;              // |dx|, |dy|
    localparam int SUM_W   = 32;              // dx^2 + dy^2
    localparam int RAD_W   = 62;              // sum shifted by 30
    localparam int ROOT_W  = 31;
    localparam int REM_W   = 35;
    localparam int NUM_W   = 26;              // |d| * width
    localparam int QUO_W   = 26;
    localparam int DREM_W  = 32;
    localparam int ACC_W   = 33;              // q16 vertex before rounding
    localparam int SQRT_STEPS = 31;
    localparam int DIV_STEPS  = 26;
    localparam int STEP_W     = 5;

    typedef enum logic [3:0] {
        S_IDLE, S_RA, S_RB, S_RC, S_SQ1, S_SQ2, S_SQRT, S_DIV, S_OUT, S_WAIT
    } t_state;

    // round a q16 value to integer, halves away from zero
    function automatic logic signed [VTX_W-1:0] round_q16(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-1:0] mag;
        logic [ACC_W-1:0] rq;
        logic [VTX_W-1:0] res;
        mag = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
        rq  = (mag + ACC_W'(32768)) >> 16;
        res = rq[VTX_W-1:0];
        return v[ACC_W-1] ? VTX_W'(-res) : res;
    endfunction

endpackage

### hw/rtl/ple_if.sv
// valid/ready channels of the polyline extruder: points, vertices, width
// depends on ple_pkg for field widths
interface ple_pt_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [ple_pkg::COORD_W-1:0]     point_x;
    logic signed [ple_pkg::COORD_W-1:0]     point_y;
    logic                                   last_point;
    modport source(output valid, point_x, point_y, last_point, input ready);
    modport sink(input valid, point_x, point_y, last_point, output ready);
endinterface

interface ple_vtx_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [ple_pkg::VTX_W-1:0]       vertex_x;
    logic signed [ple_pkg::VTX_W-1:0]       vertex_y;
    logic                                   on_right_side;
    logic                                   last_vertex;
    logic                                   points_dropped;
    modport source(output valid, vertex_x, vertex_y, on_right_side, last_vertex,
                   points_dropped, input ready);
    modport sink(input valid, vertex_x, vertex_y, on_right_side, last_vertex,
                 points_dropped, output ready);
endinterface

interface ple_cfg_if;
    logic                                   valid;
    logic                                   ready;
    logic [ple_pkg::TW_W-1:0]               trail_width;
    modport source(output valid, trail_width, input ready);
    modport sink(input valid, trail_width, output ready);
endinterface

### hw/rtl/polyline_extrude_to_polygon.sv
// top level of the polyline extruder: point store, normal unit, vertex output
// depends on ple_pkg, ple_if and ple_ram
//
// Points are taken one word per cycle and stored in two rams (x and y) of
// MAX_POINTS entries; points beyond that are dropped and flagged on every vertex.
// A point with last_point set starts output; no point is taken until the whole
// polygon (2n vertices: left edge in order, then right edge reversed) has gone
// out. Each vertex goes through three ram reads, the squaring states S_SQ1 and
// S_SQ2, a 31-step bit-serial square root and a 26-step restoring divide (x and
// y offsets in parallel), a rounding state and the output handshake, where it
// may stall. Every vertex recomputes its normal.
module polyline_extrude_to_polygon #(
    parameter int MAX_POINTS = ple_pkg::MAX_POINTS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ple_pt_if.sink        i_pt,
    ple_vtx_if.source     o_vtx,
    ple_cfg_if.sink       i_cfg
);
    localparam int IW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    ple_pkg::t_state r_state, n_state;

    logic [ple_pkg::TW_W-1:0] r_width;
    logic [CW-1:0]            r_count;
    logic                     r_ovf;
    logic [IW-1:0]            r_idx;
    logic                     r_pass;

    logic signed [ple_pkg::COORD_W-1:0] r_ax, r_ay, r_cx, r_cy;
    logic [ple_pkg::DIFF_W-1:0]  r_adx, r_ady;
    logic                        r_dxneg, r_dyneg;
    logic [ple_pkg::SUM_W-1:0]   r_s;
    logic [ple_pkg::NUM_W-1:0]   r_nx, r_ny;
    logic [ple_pkg::RAD_W-1:0]   r_rad;
    logic [ple_pkg::REM_W-1:0]   r_rem;
    logic [ple_pkg::ROOT_W-1:0]  r_root;
    logic [ple_pkg::DREM_W-1:0]  r_drx, r_dry;
    logic [ple_pkg::QUO_W-1:0]   r_qx, r_qy;
    logic [ple_pkg::STEP_W-1:0]  r_step;

    logic signed [ple_pkg::VTX_W-1:0] r_vx, r_vy;
    logic r_vvalid, r_vright, r_vlast, r_vdrop;

    logic in_fire, out_fire, store_we, idx_last;
    logic [IW-1:0] rd_addr, prev_idx, next_idx;
    logic signed [ple_pkg::COORD_W-1:0] x_rd, y_rd;
    logic signed [ple_pkg::DIFF_W-1:0] dx, dy;
    logic [ple_pkg::SUM_W-1:0] s_tot;
    logic [ple_pkg::REM_W-1:0] sq_rem, sq_trial;
    logic [ple_pkg::DREM_W-1:0] drx_sh, dry_sh, div_d;
    logic signed [ple_pkg::ACC_W-1:0] cxq, cyq, offx, offy, sumx, sumy;

    assign in_fire  = i_pt.valid && i_pt.ready;
    assign out_fire = r_vvalid && o_vtx.ready;
    assign store_we = in_fire && (r_count < CW'(MAX_POINTS));
    assign idx_last = ({{(CW-IW){1'b0}}, r_idx} == r_count - CW'(1));
    assign prev_idx = (r_idx == '0) ? r_idx : r_idx - IW'(1);
    assign next_idx = idx_last ? r_idx : r_idx + IW'(1);

    // point stores
    ple_ram #(.WIDTH(ple_pkg::COORD_W), .DEPTH(MAX_POINTS)) u_xram (
        .i_clk(i_clk), .i_we(store_we), .i_waddr(r_count[IW-1:0]),
        .i_wdata(i_pt.point_x), .i_raddr(rd_addr), .o_rdata(x_rd)
    );
    ple_ram #(.WIDTH(ple_pkg::COORD_W), .DEPTH(MAX_POINTS)) u_yram (
        .i_clk(i_clk), .i_we(store_we), .i_waddr(r_count[IW-1:0]),
        .i_wdata(i_pt.point_y), .i_raddr(rd_addr), .o_rdata(y_rd)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ple_pkg::S_IDLE: if (in_fire && i_pt.last_point) n_state = ple_pkg::S_RA;
            ple_pkg::S_RA:   n_state = ple_pkg::S_RB;
            ple_pkg::S_RB:   n_state = ple_pkg::S_RC;
            ple_pkg::S_RC:   n_state = ple_pkg::S_SQ1;
            ple_pkg::S_SQ1:  n_state = ple_pkg::S_SQ2;
            ple_pkg::S_SQ2:  n_state = ple_pkg::S_SQRT;
            ple_pkg::S_SQRT: begin
                if (r_step == ple_pkg::STEP_W'(ple_pkg::SQRT_STEPS - 1))
                    n_state = ple_pkg::S_DIV;
            end
            ple_pkg::S_DIV: begin
                if (r_step == ple_pkg::STEP_W'(ple_pkg::DIV_STEPS - 1))
                    n_state = ple_pkg::S_OUT;
            end
            ple_pkg::S_OUT:  n_state = ple_pkg::S_WAIT;
            ple_pkg::S_WAIT: begin
                if (out_fire)
                    n_state = (r_pass && r_idx == '0) ? ple_pkg::S_IDLE : ple_pkg::S_RA;
            end
            default: n_state = ple_pkg::S_IDLE;
        endcase
    end

    // state outputs: input ready and ram read address
    always_comb begin
        i_pt.ready = 1'b0;
        rd_addr    = r_idx;
        unique case (r_state)
            ple_pkg::S_IDLE: i_pt.ready = 1'b1;
            ple_pkg::S_RA:   rd_addr = prev_idx;
            ple_pkg::S_RB:   rd_addr = next_idx;
            default:         rd_addr = r_idx;
        endcase
    end

    // arithmetic helpers
    assign dx       = ple_pkg::DIFF_W'(x_rd) - ple_pkg::DIFF_W'(r_ax);
    assign dy       = ple_pkg::DIFF_W'(y_rd) - ple_pkg::DIFF_W'(r_ay);
    assign s_tot    = r_s + ple_pkg::SUM_W'(r_ady * r_ady);
    assign sq_rem   = {r_rem[ple_pkg::REM_W-3:0], r_rad[ple_pkg::RAD_W-1 -: 2]};
    assign sq_trial = {2'b00, r_root, 2'b01};
    assign div_d    = {1'b0, r_root};
    assign drx_sh   = {r_drx[ple_pkg::DREM_W-2:0], 1'b0};
    assign dry_sh   = {r_dry[ple_pkg::DREM_W-2:0], 1'b0};
    assign cxq  = {{2{r_cx[ple_pkg::COORD_W-1]}}, r_cx, 16'h0000};
    assign cyq  = {{2{r_cy[ple_pkg::COORD_W-1]}}, r_cy, 16'h0000};
    assign offx = r_dyneg ? ple_pkg::ACC_W'(r_qy) : -ple_pkg::ACC_W'(r_qy);
    assign offy = r_dxneg ? -ple_pkg::ACC_W'(r_qx) : ple_pkg::ACC_W'(r_qx);
    assign sumx = r_pass ? cxq - offx : cxq + offx;
    assign sumy = r_pass ? cyq - offy : cyq + offy;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ple_pkg::S_IDLE;
            r_width  <= ple_pkg::TW_RESET;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_idx    <= '0;
            r_pass   <= 1'b0;
            r_vvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready) r_width <= i_cfg.trail_width;
            if (in_fire) begin
                if (store_we) r_count <= r_count + CW'(1);
                else          r_ovf   <= 1'b1;
                r_idx  <= '0;
                r_pass <= 1'b0;
            end
            if (r_state == ple_pkg::S_OUT) r_vvalid <= 1'b1;
            // advance the vertex walk
            if (out_fire) begin
                r_vvalid <= 1'b0;
                if (!r_pass) begin
                    if (idx_last) r_pass <= 1'b1;
                    else          r_idx  <= r_idx + IW'(1);
                end else if (r_idx == '0) begin
                    r_count <= '0;
                    r_ovf   <= 1'b0;
                end else begin
                    r_idx <= r_idx - IW'(1);
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ple_pkg::S_RB: begin
                r_ax <= x_rd;
                r_ay <= y_rd;
            end
            ple_pkg::S_RC: begin
                r_adx   <= dx[ple_pkg::DIFF_W-1] ? ple_pkg::DIFF_W'(-dx) : dx;
                r_ady   <= dy[ple_pkg::DIFF_W-1] ? ple_pkg::DIFF_W'(-dy) : dy;
                r_dxneg <= dx[ple_pkg::DIFF_W-1];
                r_dyneg <= dy[ple_pkg::DIFF_W-1];
            end
            ple_pkg::S_SQ1: begin
                r_cx <= x_rd;
                r_cy <= y_rd;
                r_s  <= ple_pkg::SUM_W'(r_adx * r_adx);
                r_nx <= ple_pkg::NUM_W'(r_adx * r_width);
            end
            ple_pkg::S_SQ2: begin
                r_ny   <= ple_pkg::NUM_W'(r_ady * r_width);
                r_rad  <= {((s_tot == '0) ? ple_pkg::SUM_W'(1) : s_tot), 30'd0};
                r_rem  <= '0;
                r_root <= '0;
                r_step <= '0;
            end
            // one root bit per cycle
            ple_pkg::S_SQRT: begin
                r_rad  <= {r_rad[ple_pkg::RAD_W-3:0], 2'b00};
                if (sq_rem >= sq_trial) begin
                    r_rem  <= sq_rem - sq_trial;
                    r_root <= {r_root[ple_pkg::ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem  <= sq_rem;
                    r_root <= {r_root[ple_pkg::ROOT_W-2:0], 1'b0};
                end
                r_drx  <= {2'b00, r_nx, 4'h0};
                r_dry  <= {2'b00, r_ny, 4'h0};
                r_step <= (r_step == ple_pkg::STEP_W'(ple_pkg::SQRT_STEPS - 1))
                          ? '0 : r_step + ple_pkg::STEP_W'(1);
            end
            // one quotient bit per cycle for both offsets
            ple_pkg::S_DIV: begin
                if (drx_sh >= div_d) begin
                    r_drx <= drx_sh - div_d;
                    r_qx  <= {r_qx[ple_pkg::QUO_W-2:0], 1'b1};
                end else begin
                    r_drx <= drx_sh;
                    r_qx  <= {r_qx[ple_pkg::QUO_W-2:0], 1'b0};
                end
                if (dry_sh >= div_d) begin
                    r_dry <= dry_sh - div_d;
                    r_qy  <= {r_qy[ple_pkg::QUO_W-2:0], 1'b1};
                end else begin
                    r_dry <= dry_sh;
                    r_qy  <= {r_qy[ple_pkg::QUO_W-2:0], 1'b0};
                end
                r_step <= r_step + ple_pkg::STEP_W'(1);
            end
            ple_pkg::S_OUT: begin
                r_vx     <= ple_pkg::round_q16(sumx);
                r_vy     <= ple_pkg::round_q16(sumy);
                r_vright <= r_pass;
                r_vlast  <= r_pass && (r_idx == '0);
                r_vdrop  <= r_ovf;
            end
            default: begin
            end
        endcase
    end

    // output word and config handshake
    assign o_vtx.valid          = r_vvalid;
    assign o_vtx.vertex_x       = r_vx;
    assign o_vtx.vertex_y       = r_vy;
    assign o_vtx.on_right_side  = r_vright;
    assign o_vtx.last_vertex    = r_vlast;
    assign o_vtx.points_dropped = r_vdrop;
    assign i_cfg.ready          = 1'b1;
endmodule

### hw/rtl/ple_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no package dependency
module ple_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### hw/rtl/ple_checker.sv
// port-level checks of the polyline extruder, bound to the top level
// depends on ple_pkg and polyline_extrude_to_polygon_assert.svh
`include "polyline_extrude_to_polygon_assert.svh"

module ple_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_pt_valid,
    input logic                             i_pt_ready,
    input logic                             i_pt_last,
    input logic                             i_vtx_valid,
    input logic                             i_vtx_ready,
    input logic signed [ple_pkg::VTX_W-1:0] i_vtx_x,
    input logic                             i_vtx_last
);
    logic in_word, out_word;
    assign in_word  = i_pt_valid && i_pt_ready;
    assign out_word = i_vtx_valid && i_vtx_ready;

    // a stalled vertex holds
    `PLE_ASSERT_NEXT(a_hold, i_clk, i_rst_n, i_vtx_valid && !i_vtx_ready, i_vtx_valid && $stable(i_vtx_x))
    // no point is taken while a vertex is offered
    `PLE_ASSERT_NOW(a_excl, i_clk, i_rst_n, i_vtx_valid, !i_pt_ready)
    // polygon ends after its last vertex
    `PLE_ASSERT_NEXT(a_end, i_clk, i_rst_n, out_word && i_vtx_last, !i_vtx_valid)
    // a non-final point yields no vertex
    `PLE_ASSERT_NEXT(a_quiet, i_clk, i_rst_n, in_word && !i_pt_last, !i_vtx_valid)
endmodule

bind polyline_extrude_to_polygon ple_checker u_ple_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .i_pt_valid(i_pt.valid),
    .i_pt_ready(i_pt.ready),
    .i_pt_last(i_pt.last_point),
    .i_vtx_valid(o_vtx.valid),
    .i_vtx_ready(o_vtx.ready),
    .i_vtx_x(o_vtx.vertex_x),
    .i_vtx_last(o_vtx.last_vertex)
);
